// ===== rtl/isl_pkg.sv =====
`timescale 1ns / 1ps

package isl_pkg;

	localparam logic [2:0] OP_APPEND = 3'd0;
	localparam logic [2:0] OP_READ   = 3'd1;
	localparam logic [2:0] OP_INSERT = 3'd2;
	localparam logic [2:0] OP_WRITE  = 3'd3;
	localparam logic [2:0] OP_REMOVE = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]         op;
		logic [5:0]         index;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic [6:0]         count;
		logic [1:0]         status;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic shift_up;
		logic shift_down;
		logic hit;
	} cell_ctl_t;

endpackage

// ===== rtl/isl_cell.sv =====
`timescale 1ns / 1ps

module isl_cell (
	input  logic               clk,
	input  isl_pkg::cell_ctl_t ctl,
	input  logic signed [31:0] value,
	input  logic signed [31:0] prev_data,
	input  logic signed [31:0] next_data,
	output logic signed [31:0] data,
	output logic signed [31:0] rd_data
);

	logic signed [31:0] data_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			data_q <= value;
		end else if (ctl.shift_up) begin
			data_q <= prev_data;
		end else if (ctl.shift_down) begin
			data_q <= next_data;
		end
	end

	assign data    = data_q;
	assign rd_data = ctl.hit ? data_q : 32'sd0;

endmodule

// ===== rtl/indexed_shift_list.sv =====
`timescale 1ns / 1ps
// indexed_shift_list: ordered list of up to DEPTH signed 32-bit words
// held in a row of cells, one word per cell.
// Requests arrive on req (op, index, value) and are taken on any clock edge
// with start high and busy low; busy stays low, so a request can be issued
// in every cycle.
// Each request gives exactly one response on rsp, valid for one cycle while
// done is high, in the cycle right after the request is taken (throughput one
// request per cycle).
// Append, insert, overwrite and remove update all cells at the same edge: each
// cell loads the new value, takes its lower neighbor (insert) or its upper
// neighbor (remove), or holds. A read selects the addressed cell with an
// and-or over the row.
// Responses carry the word read (zero except for a good read), the count
// after the request and a status: ok, index out of range, or list full.
// Reset empties the list (count zero) and drops any pending response; cell
// contents are not cleared. The receiver cannot stall: a response must be
// taken in its done cycle.

module indexed_shift_list #(
	parameter int DEPTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  isl_pkg::req_t req,
	output logic          done,
	output isl_pkg::rsp_t rsp
);

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > 6) ? CW : 6;

	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_d;
	logic               done_q;
	isl_pkg::rsp_t      rsp_q;
	logic [1:0]         status_d;
	logic               in_range;
	logic               full;
	logic               do_app;
	logic               do_rd;
	logic               do_ins;
	logic               do_wr;
	logic               do_rem;
	logic [CMPW-1:0]    idx_x;
	logic [CMPW-1:0]    cnt_x;
	logic signed [31:0] rd_value;

	logic signed [31:0] cell_data [DEPTH];
	logic signed [31:0] cell_rd   [DEPTH];

	assign busy  = 1'b0;
	assign idx_x = CMPW'(req.index);
	assign cnt_x = CMPW'(count_q);
	assign in_range = idx_x < cnt_x;
	assign full     = count_q >= CW'(DEPTH);

	always_comb begin
		do_app   = 1'b0;
		do_rd    = 1'b0;
		do_ins   = 1'b0;
		do_wr    = 1'b0;
		do_rem   = 1'b0;
		status_d = isl_pkg::ST_OK;
		case (req.op)
			isl_pkg::OP_APPEND: begin
				if (full) begin
					status_d = isl_pkg::ST_FULL;
				end else begin
					do_app = start;
				end
			end
			isl_pkg::OP_READ: begin
				if (!in_range) begin
					status_d = isl_pkg::ST_RANGE;
				end else begin
					do_rd = start;
				end
			end
			isl_pkg::OP_INSERT: begin
				if (!in_range) begin
					status_d = isl_pkg::ST_RANGE;
				end else if (full) begin
					status_d = isl_pkg::ST_FULL;
				end else begin
					do_ins = start;
				end
			end
			isl_pkg::OP_WRITE: begin
				if (!in_range) begin
					status_d = isl_pkg::ST_RANGE;
				end else begin
					do_wr = start;
				end
			end
			isl_pkg::OP_REMOVE: begin
				if (!in_range) begin
					status_d = isl_pkg::ST_RANGE;
				end else begin
					do_rem = start;
				end
			end
			default: begin
				status_d = isl_pkg::ST_RANGE;
			end
		endcase
	end

	always_comb begin
		count_d = count_q;
		if (do_app || do_ins) begin
			count_d = count_q + CW'(1);
		end else if (do_rem) begin
			count_d = count_q - CW'(1);
		end
	end

	// row of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CMPW-1:0] POS = CMPW'(i);
		isl_pkg::cell_ctl_t ctl;
		logic signed [31:0] prev_w;
		logic signed [31:0] next_w;

		assign ctl.load = (do_app && POS == cnt_x) || ((do_wr || do_ins) && POS == idx_x);
		assign ctl.shift_up   = do_ins && POS > idx_x;
		assign ctl.shift_down = do_rem && POS >= idx_x;
		assign ctl.hit        = do_rd && POS == idx_x;

		if (i == 0) begin : g_first
			assign prev_w = 32'sd0;
		end else begin : g_mid_lo
			assign prev_w = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next_w = 32'sd0;
		end else begin : g_mid_hi
			assign next_w = cell_data[i+1];
		end

		isl_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.value     (req.value),
			.prev_data (prev_w),
			.next_data (next_w),
			.data      (cell_data[i]),
			.rd_data   (cell_rd[i])
		);
	end

	always_comb begin
		rd_value = 32'sd0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_value = rd_value | cell_rd[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			done_q  <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rsp_q.read_value <= rd_value;
			rsp_q.count      <= 7'(count_d);
			rsp_q.status     <= status_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_one_response: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> done)
		else $error("transfer not answered in the next cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("count above depth");

	a_refused_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		start && status_d != isl_pkg::ST_OK |=> count_q == $past(count_q))
		else $error("refused transfer changed count");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		start && status_d == isl_pkg::ST_FULL |-> count_q == CW'(DEPTH))
		else $error("full status with room left");

	a_read_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		start && !do_rd |=> rsp.read_value == 32'sd0)
		else $error("read value nonzero on non-read transfer");

endmodule
